FILE: rtl/ecm_pkg.sv
// Edge component merger: shared types and constants.
`default_nettype none

package ecm_pkg;

    localparam int NODE_AW  = 10;
    localparam int LABEL_W  = 9;
    localparam int SIZE_W   = 11;
    localparam int COUNT_W  = 11;
    localparam int FREE_W   = 10;
    localparam int NODES    = 1 << NODE_AW;
    localparam int LABELS   = 1 << LABEL_W;
    localparam int ENTRY_W  = LABEL_W + 1;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 24;
    localparam int RES_W    = 2 + LABEL_W + SIZE_W;

    localparam logic [COUNT_W-1:0] NODE_LIMIT       = COUNT_W'(NODES);
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(1024);
    localparam logic [SIZE_W-1:0]  PAIR_SIZE        = SIZE_W'(2);

    typedef enum logic [1:0] {
        OC_NEW    = 2'd0,
        OC_JOINED = 2'd1,
        OC_MERGED = 2'd2,
        OC_SAME   = 2'd3
    } t_outcome;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_WRITE2,
        S_WALK
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/edge_component_merger.sv
// Edge component merger: quick-find component labelling with per-component sizes.
//
// Edges arrive on the s_axis transaction channel, node_a in tdata[9:0] and
// node_b in tdata[19:10]. Each edge gives one result on m_axis: outcome,
// component label and component size. The node count register is written
// through the cfg channel, which is always ready.
// Node labels sit in a 1024 x 10 memory with two read ports, sizes in a
// 512 x 11 memory; both have registered reads.
// Each edge passes through node read, size read, and decision with write
// back before the next edge is accepted; the result register is loaded in the
// decision step. A new component adds a spare write slot for its second node.
// A merge adds a relabel walk over the nodes in use, one node per cycle; the
// result is presented at the start of the walk.
// After reset a clearing pass marks all 1024 nodes unlabeled, with
// s_axis_tready low throughout. The result sits in an output register; if
// the receiver stalls, the block finishes the next edge's lookup and then
// waits in its decision step until the register frees.
`default_nettype none

module edge_component_merger (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [ecm_pkg::IN_W-1:0]    s_axis_tdata,  // node_a, node_b
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [ecm_pkg::OUT_W-1:0]        m_axis_tdata,  // outcome, component_label,
                                                            // component_size
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [ecm_pkg::COUNT_W-1:0] i_cfg_data     // node_count
);

    localparam int AW = ecm_pkg::NODE_AW;
    localparam int LW = ecm_pkg::LABEL_W;
    localparam int SW = ecm_pkg::SIZE_W;
    localparam int CW = ecm_pkg::COUNT_W;
    localparam int EW = ecm_pkg::ENTRY_W;

    logic [EW-1:0] node_mem [ecm_pkg::NODES];
    logic [SW-1:0] size_mem [ecm_pkg::LABELS];

    ecm_pkg::t_state r_state, n_state;

    logic [CW-1:0]              r_walk;
    logic                       r_wb_valid;
    logic [AW-1:0]              r_wb_addr;
    logic [AW-1:0]              r_a, r_b;
    logic                       r_range_bad;
    logic [CW-1:0]              r_node_cnt;
    logic [ecm_pkg::FREE_W-1:0] r_next_free;
    logic [LW-1:0]              r_keep, r_drop;
    logic [EW-1:0]              r_rd_a, r_rd_b;
    logic [SW-1:0]              r_size_a, r_size_b;
    logic                       r_out_valid;
    logic [ecm_pkg::RES_W-1:0]  r_out_data;

    logic [CW-1:0] lim;
    logic [AW-1:0] in_a, in_b;
    logic          accept;
    logic          out_free;

    logic          node_we;
    logic [AW-1:0] node_waddr;
    logic [EW-1:0] node_wdata;
    logic          rd_a_en;
    logic [AW-1:0] rd_a_addr;
    logic          size_rd_en;
    logic          size_we;
    logic [LW-1:0] size_waddr;
    logic [SW-1:0] size_wdata;
    logic          out_load;
    logic [ecm_pkg::RES_W-1:0] out_data;
    logic          free_inc;
    logic          keep_load;
    logic [LW-1:0] keep_val;
    logic          walk_clr;
    logic          walk_inc;
    logic          wb_issue;

    logic          va, vb;
    logic [LW-1:0] la, lb;
    logic [SW-1:0] sum_ab;

    assign in_a     = s_axis_tdata[AW-1:0];
    assign in_b     = s_axis_tdata[2*AW-1:AW];
    assign lim      = (r_node_cnt > ecm_pkg::NODE_LIMIT) ? ecm_pkg::NODE_LIMIT : r_node_cnt;
    assign s_axis_tready = (r_state == ecm_pkg::S_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(ecm_pkg::OUT_W - ecm_pkg::RES_W)'(0), r_out_data};

    assign va     = r_rd_a[EW-1];
    assign vb     = r_rd_b[EW-1];
    assign la     = r_rd_a[LW-1:0];
    assign lb     = r_rd_b[LW-1:0];
    assign sum_ab = r_size_a + r_size_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecm_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        node_we    = 1'b0;
        node_waddr = r_walk[AW-1:0];
        node_wdata = '0;
        rd_a_en    = 1'b0;
        rd_a_addr  = in_a;
        size_rd_en = 1'b0;
        size_we    = 1'b0;
        size_waddr = la;
        size_wdata = '0;
        out_load   = 1'b0;
        out_data   = {SW'(0), LW'(0), ecm_pkg::OC_SAME};
        free_inc   = 1'b0;
        keep_load  = 1'b0;
        keep_val   = la;
        walk_clr   = 1'b0;
        walk_inc   = 1'b0;
        wb_issue   = 1'b0;
        unique case (r_state)
            ecm_pkg::S_CLEAR: begin
                node_we  = 1'b1;
                walk_inc = 1'b1;
                if (r_walk[AW-1:0] == AW'(ecm_pkg::NODES - 1)) begin
                    n_state = ecm_pkg::S_IDLE;
                end
            end
            ecm_pkg::S_IDLE: begin
                if (accept) begin
                    rd_a_en = 1'b1;
                    n_state = ecm_pkg::S_LOOKUP;
                end
            end
            ecm_pkg::S_LOOKUP: begin
                size_rd_en = 1'b1;
                n_state    = ecm_pkg::S_DECIDE;
            end
            ecm_pkg::S_DECIDE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ecm_pkg::S_IDLE;
                    priority if (r_range_bad || (r_a == r_b && !va)) begin
                        out_data = {SW'(0), LW'(0), ecm_pkg::OC_SAME};
                    end else if (!va && !vb) begin
                        node_we    = 1'b1;
                        node_waddr = r_a;
                        node_wdata = {1'b1, r_next_free[LW-1:0]};
                        size_we    = 1'b1;
                        size_waddr = r_next_free[LW-1:0];
                        size_wdata = ecm_pkg::PAIR_SIZE;
                        free_inc   = 1'b1;
                        keep_load  = 1'b1;
                        keep_val   = r_next_free[LW-1:0];
                        out_data   = {ecm_pkg::PAIR_SIZE, r_next_free[LW-1:0],
                                      ecm_pkg::OC_NEW};
                        n_state    = ecm_pkg::S_WRITE2;
                    end else if (va != vb) begin
                        node_we    = 1'b1;
                        node_waddr = va ? r_b : r_a;
                        node_wdata = {1'b1, va ? la : lb};
                        size_we    = 1'b1;
                        size_waddr = va ? la : lb;
                        size_wdata = (va ? r_size_a : r_size_b) + SW'(1);
                        out_data   = {size_wdata, size_waddr, ecm_pkg::OC_JOINED};
                    end else if (la == lb) begin
                        out_data = {r_size_a, la, ecm_pkg::OC_SAME};
                    end else begin
                        size_we    = 1'b1;
                        size_waddr = la;
                        size_wdata = sum_ab;
                        keep_load  = 1'b1;
                        keep_val   = la;
                        walk_clr   = 1'b1;
                        out_data   = {sum_ab, la, ecm_pkg::OC_MERGED};
                        n_state    = ecm_pkg::S_WALK;
                    end
                end
            end
            ecm_pkg::S_WRITE2: begin
                node_we    = 1'b1;
                node_waddr = r_b;
                node_wdata = {1'b1, r_keep};
                n_state    = ecm_pkg::S_IDLE;
            end
            ecm_pkg::S_WALK: begin
                if (r_walk == '0) begin
                    size_we    = 1'b1;
                    size_waddr = r_drop;
                    size_wdata = '0;
                end
                if (r_walk < lim) begin
                    rd_a_en   = 1'b1;
                    rd_a_addr = r_walk[AW-1:0];
                    walk_inc  = 1'b1;
                    wb_issue  = 1'b1;
                end
                if (r_wb_valid && va && la == r_drop) begin
                    node_we    = 1'b1;
                    node_waddr = r_wb_addr;
                    node_wdata = {1'b1, r_keep};
                end
                if (r_walk >= lim && !r_wb_valid) begin
                    n_state = ecm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ecm_pkg::S_IDLE;
            end
        endcase
    end

    // label memory: two read ports, one write port
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (rd_a_en) begin
            r_rd_a <= node_mem[rd_a_addr];
        end
        if (accept) begin
            r_rd_b <= node_mem[in_b];
        end
    end

    // size memory
    always_ff @(posedge i_clk) begin
        if (size_we) begin
            size_mem[size_waddr] <= size_wdata;
        end
        if (size_rd_en) begin
            r_size_a <= size_mem[la];
            r_size_b <= size_mem[lb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk      <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_next_free <= '0;
            r_node_cnt  <= ecm_pkg::NODE_COUNT_RESET;
        end else begin
            if (walk_clr) begin
                r_walk <= '0;
            end else if (walk_inc) begin
                r_walk <= r_walk + CW'(1);
            end
            r_wb_valid <= wb_issue;
            if (free_inc) begin
                r_next_free <= r_next_free + ecm_pkg::FREE_W'(1);
            end
            if (i_cfg_valid) begin
                r_node_cnt <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_addr <= r_walk[AW-1:0];
        if (accept) begin
            r_a         <= in_a;
            r_b         <= in_b;
            r_range_bad <= ({1'b0, in_a} >= lim) || ({1'b0, in_b} >= lim);
        end
        if (keep_load) begin
            r_keep <= keep_val;
        end
        if (walk_clr) begin
            r_drop <= lb;
        end
        if (out_load) begin
            r_out_data <= out_data;
        end
    end

endmodule

`default_nettype wire
